// ===== rtl/kgp_pkg.sv =====
// kgp_pkg: shared types, constants and the gait keyframe rom for the keyframe gait player
// no dependencies

package kgp_pkg;

    localparam int NUM_KEYFRAMES = 8;
    localparam int NUM_JOINTS    = 4;
    localparam int KF_W          = $clog2(NUM_KEYFRAMES);
    localparam int JNT_W         = $clog2(NUM_JOINTS);

    localparam int ANGLE_W = 16;
    localparam int TIME_W  = 16;
    localparam int LOOP_W  = 4;
    localparam int CFG_W   = 3;

    // configuration register indexes
    localparam logic [CFG_W-1:0] CFG_IDLE_HIP         = 3'd0;
    localparam logic [CFG_W-1:0] CFG_IDLE_ROLL        = 3'd1;
    localparam logic [CFG_W-1:0] CFG_IDLE_KNEE        = 3'd2;
    localparam logic [CFG_W-1:0] CFG_IDLE_ANKLE       = 3'd3;
    localparam logic [CFG_W-1:0] CFG_TRANSITION_TIME  = 3'd4;
    localparam logic [CFG_W-1:0] CFG_SEGMENT_TIME     = 3'd5;
    localparam logic [CFG_W-1:0] CFG_LOOP_TOTAL       = 3'd6;
    localparam logic [CFG_W-1:0] CFG_RETURN_TIME      = 3'd7;

    localparam logic signed [ANGLE_W-1:0] IDLE_RESET [NUM_JOINTS] =
        '{16'sd1393, 16'sd0, 16'sd2744, 16'sd1434};

    localparam logic [TIME_W-1:0] TRANSITION_RESET = 16'd3000;
    localparam logic [TIME_W-1:0] SEGMENT_RESET    = 16'd500;
    localparam logic [LOOP_W-1:0] LOOP_RESET       = 4'd5;
    localparam logic [TIME_W-1:0] RETURN_RESET     = 16'd3000;

    localparam logic [LOOP_W-1:0] LOOP_MAX = 4'd15;

    // gait poses in q4.12 radians: hip, hip roll, knee, ankle
    localparam logic signed [ANGLE_W-1:0] GAIT_ROM [NUM_KEYFRAMES][NUM_JOINTS] = '{
        '{ 16'sd2458,  16'sd0,    16'sd6431,  16'sd0    },
        '{ 16'sd3195,  16'sd410,  16'sd2867, -16'sd614  },
        '{ 16'sd2458,  16'sd819,  16'sd2048, -16'sd1024 },
        '{-16'sd819,   16'sd410,  16'sd819,   16'sd1024 },
        '{-16'sd1434,  16'sd0,    16'sd819,   16'sd819  },
        '{-16'sd1843, -16'sd410,  16'sd3195,  16'sd2458 },
        '{-16'sd2662, -16'sd819,  16'sd4096, -16'sd1843 },
        '{ 16'sd1229, -16'sd410,  16'sd7168, -16'sd819  }
    };

    typedef enum logic [1:0] {
        PH_TRANSITION = 2'd0,
        PH_WALK       = 2'd1,
        PH_RETURN     = 2'd2,
        PH_DONE       = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SQ,
        S_EASE,
        S_SMOOTH,
        S_JMUL,
        S_JADD,
        S_OUT
    } seq_state_t;

endpackage

// ===== rtl/keyframe_gait_player_core.sv =====
// keyframe_gait_player_core: timer, phase sequencer and shared divide/multiply datapath
// depends on kgp_pkg

// Usage
// Each request on the input channel carries a time step in ms. The block adds it to a
// saturating phase timer, forms alpha = elapsed/duration in q0.16 with a bit-serial
// divider, eases it with smoothstep and blends the four joint angles through one shared
// multiplier. Exactly one result follows each request, carrying the pose and the phase,
// segment and loop count that the pose was computed from.
// The accepting edge starts the bit-serial divider for alpha; the smoothstep steps then
// square it and multiply by 3 - 2a, and each joint passes through a multiply step and an
// add step before the output step loads the result register. When the timer has reached
// the duration, alpha is one and the divide and smoothstep steps are skipped. A new
// request is taken only when the sequencer is back in idle.
// The result sits in an output register; if the receiver stalls, the next finished result
// waits in the sequencer until the register is free, and no request is taken meanwhile.
// Configuration writes are always taken and are meant to arrive while the block is idle.
// Reset restores the default idle pose, timings and loop total and starts in the
// transition phase with the timer, segment and loop counts at zero.

module keyframe_gait_player_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       time_step,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [kgp_pkg::ANGLE_W-1:0] hip_angle,
    output logic signed [kgp_pkg::ANGLE_W-1:0] roll_angle,
    output logic signed [kgp_pkg::ANGLE_W-1:0] knee_angle,
    output logic signed [kgp_pkg::ANGLE_W-1:0] ankle_angle,
    output logic [1:0]                       phase,
    output logic [2:0]                       segment_index,
    output logic [3:0]                       loop_index,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kgp_pkg::CFG_W-1:0]        cfg_index,
    input  logic [15:0]                      cfg_data
);
    import kgp_pkg::*;

    // configuration
    logic signed [ANGLE_W-1:0] idle_reg [NUM_JOINTS];
    logic [TIME_W-1:0]         transition_time_reg;
    logic [TIME_W-1:0]         segment_time_reg;
    logic [LOOP_W-1:0]         loop_total_reg;
    logic [TIME_W-1:0]         return_time_reg;

    // control state
    seq_state_t        state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [TIME_W-1:0] elapsed_reg, elapsed_next;
    logic [KF_W-1:0]   seg_reg, seg_next;
    logic [LOOP_W-1:0] loop_reg, loop_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic              out_valid_reg, out_valid_next;

    // datapath
    logic [TIME_W-1:0]         dur_reg, dur_next;
    logic [15:0]               rem_reg, rem_next;
    logic [15:0]               quo_reg, quo_next;
    logic [16:0]               s_reg, s_next;
    logic signed [51:0]        prod_reg, prod_next;
    logic signed [ANGLE_W-1:0] pose_reg [NUM_JOINTS];
    logic signed [ANGLE_W-1:0] out_pose_reg [NUM_JOINTS];
    phase_t                    out_phase_reg;
    logic [KF_W-1:0]           out_seg_reg;
    logic [LOOP_W-1:0]         out_loop_reg;

    logic              in_fire, cfg_fire, load_out;
    logic [TIME_W:0]   el_sum;
    logic [TIME_W-1:0] el_new, dur_sel;
    logic              done_sel;
    logic [KF_W-1:0]   nxt;
    logic [LOOP_W-1:0] loop_inc;
    logic [16:0]       rem_sh;
    logic              rem_ge;
    logic [JNT_W-1:0]  jnt;
    logic signed [ANGLE_W-1:0] from_ang, to_ang;
    logic signed [ANGLE_W:0]   diff;
    logic [17:0]               ease_k;
    logic signed [32:0]        mul_a;
    logic signed [18:0]        mul_b;
    logic signed [51:0]        mul_p;
    logic signed [51:0]        rnd;
    logic signed [ANGLE_W-1:0] blended;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_valid = out_valid_reg;
    assign load_out  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    assign el_sum = {1'b0, elapsed_reg} + {9'd0, time_step};
    assign el_new = el_sum[TIME_W] ? {TIME_W{1'b1}} : el_sum[TIME_W-1:0];

    always_comb
    begin
        unique case (phase_reg)
            PH_TRANSITION: dur_sel = transition_time_reg;
            PH_WALK:       dur_sel = segment_time_reg;
            default:       dur_sel = return_time_reg;
        endcase
    end

    assign done_sel = (dur_sel == '0) || (el_new >= dur_sel);
    assign nxt      = (seg_reg == KF_W'(NUM_KEYFRAMES - 1)) ? '0 : seg_reg + 1'b1;
    assign loop_inc = (loop_reg < LOOP_MAX) ? loop_reg + 1'b1 : loop_reg;

    // one quotient bit per cycle
    assign rem_sh = {rem_reg, 1'b0};
    assign rem_ge = rem_sh >= {1'b0, dur_reg};

    assign jnt = cnt_reg[JNT_W-1:0];

    always_comb
    begin
        unique case (phase_reg)
            PH_TRANSITION:
            begin
                from_ang = idle_reg[jnt];
                to_ang   = GAIT_ROM[0][jnt];
            end
            PH_WALK:
            begin
                from_ang = GAIT_ROM[seg_reg][jnt];
                to_ang   = GAIT_ROM[nxt][jnt];
            end
            PH_RETURN:
            begin
                from_ang = GAIT_ROM[0][jnt];
                to_ang   = idle_reg[jnt];
            end
            default:
            begin
                from_ang = idle_reg[jnt];
                to_ang   = idle_reg[jnt];
            end
        endcase
    end

    assign diff   = {to_ang[ANGLE_W-1], to_ang} - {from_ang[ANGLE_W-1], from_ang};
    // 3 - 2a in q2.16
    assign ease_k = 18'h30000 - {1'b0, quo_reg, 1'b0};

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            S_SQ:
            begin
                mul_a = {17'd0, quo_reg};
                mul_b = {3'd0, quo_reg};
            end
            S_EASE:
            begin
                mul_a = {1'b0, prod_reg[31:0]};
                mul_b = {1'b0, ease_k};
            end
            default:
            begin
                mul_a = {{16{diff[ANGLE_W]}}, diff};
                mul_b = {2'd0, s_reg};
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    // round half up, then keep the low bits of the arithmetic shift
    assign rnd     = prod_reg + 52'sd32768;
    assign blended = from_ang + rnd[31:16];

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        seg_next       = seg_reg;
        loop_next      = loop_reg;
        cnt_next       = cnt_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        dur_next       = dur_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        s_next         = s_reg;
        prod_next      = prod_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    elapsed_next = el_new;
                    dur_next     = dur_sel;
                    done_next    = done_sel;
                    rem_next     = el_new;
                    quo_next     = '0;
                    cnt_next     = '0;
                    s_next       = 17'h10000;
                    state_next   = done_sel ? S_JMUL : S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = rem_ge ? 16'(rem_sh - {1'b0, dur_reg}) : rem_sh[15:0];
                quo_next = {quo_reg[14:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd15)
                    state_next = S_SQ;
            end
            S_SQ:
            begin
                prod_next  = mul_p;
                state_next = S_EASE;
            end
            S_EASE:
            begin
                prod_next  = mul_p;
                state_next = S_SMOOTH;
            end
            S_SMOOTH:
            begin
                s_next     = {1'b0, prod_reg[47:32]};
                cnt_next   = '0;
                state_next = S_JMUL;
            end
            S_JMUL:
            begin
                prod_next  = mul_p;
                state_next = S_JADD;
            end
            S_JADD:
            begin
                if (jnt == JNT_W'(NUM_JOINTS - 1))
                    state_next = S_OUT;
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_JMUL;
                end
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (phase_reg != PH_DONE && done_reg)
                    begin
                        elapsed_next = '0;
                        unique case (phase_reg)
                            PH_TRANSITION:
                            begin
                                phase_next = PH_WALK;
                                seg_next   = '0;
                                loop_next  = '0;
                            end
                            PH_WALK:
                            begin
                                seg_next = nxt;
                                if (nxt == '0)
                                begin
                                    loop_next = loop_inc;
                                    if (loop_inc >= loop_total_reg)
                                        phase_next = PH_RETURN;
                                end
                            end
                            default:
                                phase_next = PH_DONE;
                        endcase
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_TRANSITION;
            elapsed_reg   <= '0;
            seg_reg       <= '0;
            loop_reg      <= '0;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            seg_reg       <= seg_next;
            loop_reg      <= loop_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_JOINTS; i++)
                idle_reg[i] <= IDLE_RESET[i];
            transition_time_reg <= TRANSITION_RESET;
            segment_time_reg    <= SEGMENT_RESET;
            loop_total_reg      <= LOOP_RESET;
            return_time_reg     <= RETURN_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_IDLE_HIP:         idle_reg[0]         <= cfg_data;
                CFG_IDLE_ROLL:        idle_reg[1]         <= cfg_data;
                CFG_IDLE_KNEE:        idle_reg[2]         <= cfg_data;
                CFG_IDLE_ANKLE:       idle_reg[3]         <= cfg_data;
                CFG_TRANSITION_TIME:  transition_time_reg <= cfg_data;
                CFG_SEGMENT_TIME:     segment_time_reg    <= cfg_data;
                CFG_LOOP_TOTAL:       loop_total_reg      <= cfg_data[LOOP_W-1:0];
                CFG_RETURN_TIME:      return_time_reg     <= cfg_data;
                default:              ;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        dur_reg  <= dur_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        s_reg    <= s_next;
        prod_reg <= prod_next;
        if (state_reg == S_JADD)
            pose_reg[jnt] <= blended;
        if (load_out)
        begin
            for (int i = 0; i < NUM_JOINTS; i++)
                out_pose_reg[i] <= pose_reg[i];
            out_phase_reg <= phase_reg;
            out_seg_reg   <= seg_reg;
            out_loop_reg  <= loop_reg;
        end
    end

    assign hip_angle     = out_pose_reg[0];
    assign roll_angle    = out_pose_reg[1];
    assign knee_angle    = out_pose_reg[2];
    assign ankle_angle   = out_pose_reg[3];
    assign phase         = out_phase_reg;
    assign segment_index = out_seg_reg;
    assign loop_index    = out_loop_reg;

endmodule
